/* design/bid_pkg.sv */
// shared types, opcode names and operand-size table for the bytecode decoder
// no dependencies; imported by every module of the decoder
package bid_pkg;

	localparam int SEQ_WIDTH  = 32;
	localparam int TDATA_BITS = 176;

	// result kinds
	typedef enum logic [2:0] {
		KIND_DECODED = 3'd0,
		KIND_SKIPPED = 3'd1,
		KIND_TRUNC   = 3'd2,
		KIND_BADPAD  = 3'd3,
		KIND_END     = 3'd4
	} kind_t;

	// opcodes with a field layout of their own
	localparam logic [7:0] OP_NOP                   = 8'h00;
	localparam logic [7:0] OP_MOVE                  = 8'h01;
	localparam logic [7:0] OP_MOVE_FROM16           = 8'h02;
	localparam logic [7:0] OP_MOVE_16               = 8'h03;
	localparam logic [7:0] OP_MOVE_WIDE             = 8'h04;
	localparam logic [7:0] OP_MOVE_WIDE_FROM16      = 8'h05;
	localparam logic [7:0] OP_MOVE_WIDE_16          = 8'h06;
	localparam logic [7:0] OP_MOVE_OBJECT           = 8'h07;
	localparam logic [7:0] OP_MOVE_OBJECT_FROM16    = 8'h08;
	localparam logic [7:0] OP_MOVE_OBJECT_16        = 8'h09;
	localparam logic [7:0] OP_RETURN_VOID           = 8'h0E;
	localparam logic [7:0] OP_CONST_4               = 8'h12;
	localparam logic [7:0] OP_CONST_16              = 8'h13;
	localparam logic [7:0] OP_CONST                 = 8'h14;
	localparam logic [7:0] OP_CONST_HIGH16          = 8'h15;
	localparam logic [7:0] OP_CONST_WIDE_16         = 8'h16;
	localparam logic [7:0] OP_CONST_WIDE_32         = 8'h17;
	localparam logic [7:0] OP_CONST_WIDE            = 8'h18;
	localparam logic [7:0] OP_CONST_WIDE_HIGH16     = 8'h19;
	localparam logic [7:0] OP_CONST_STRING          = 8'h1A;
	localparam logic [7:0] OP_CONST_STRING_JUMBO    = 8'h1B;
	localparam logic [7:0] OP_CONST_CLASS           = 8'h1C;
	localparam logic [7:0] OP_CHECK_CAST            = 8'h1F;
	localparam logic [7:0] OP_INSTANCE_OF           = 8'h20;
	localparam logic [7:0] OP_ARRAY_LENGTH          = 8'h21;
	localparam logic [7:0] OP_NEW_INSTANCE          = 8'h22;
	localparam logic [7:0] OP_NEW_ARRAY             = 8'h23;
	localparam logic [7:0] OP_INVOKE_VIRTUAL_RANGE  = 8'h74;
	localparam logic [7:0] OP_INVOKE_SUPER_RANGE    = 8'h75;
	localparam logic [7:0] OP_INVOKE_DIRECT_RANGE   = 8'h76;
	localparam logic [7:0] OP_INVOKE_STATIC_RANGE   = 8'h77;
	localparam logic [7:0] OP_INVOKE_IFACE_RANGE    = 8'h78;

	// one result word
	typedef struct packed {
		logic [7:0]     opcode;
		kind_t          kind;
		logic [15:0]    reg_a;
		logic [15:0]    reg_b;
		logic [31:0]    pool_index;
		logic [7:0]     reg_count;
		logic [63:0]    literal;
		logic [31:0]    seq_number;
		logic           last_of_segment;
	} res_t;

	// decoded field group from the field decoder
	typedef struct packed {
		logic [15:0] reg_a;
		logic [15:0] reg_b;
		logic [31:0] pool_index;
		logic [7:0]  reg_count;
		logic [63:0] literal;
	} fields_t;

	function automatic logic is_decoded(input logic [7:0] op);
		return (op <= OP_NEW_ARRAY) ||
			(op >= OP_INVOKE_VIRTUAL_RANGE && op <= OP_INVOKE_IFACE_RANGE);
	endfunction

	// operand bytes that follow each opcode
	function automatic logic [3:0] op_size(input logic [7:0] op);
		logic [3:0] n;
		n = 4'd1;
		unique case (op) inside
			8'h02, 8'h05, 8'h08, 8'h13, 8'h15, 8'h16, 8'h19, 8'h1A, 8'h1C, 8'h1F,
			8'h20, 8'h22, 8'h23, 8'h29, [8'h2D:8'h3D], [8'h44:8'h6D],
			[8'h90:8'hAF], [8'hD0:8'hE2]:
				n = 4'd3;
			8'h03, 8'h06, 8'h09, 8'h14, 8'h17, 8'h1B, [8'h24:8'h26], [8'h2A:8'h2C],
			[8'h6E:8'h72], [8'h74:8'h78]:
				n = 4'd5;
			8'h18:
				n = 4'd9;
			default:
				n = 4'd1;
		endcase
		return n;
	endfunction

endpackage

/* design/bid_fields.sv */
// field decoder: maps an assembled instruction onto register, pool, count and literal fields
// depends on bid_pkg
module bid_fields import bid_pkg::*; (
	input  logic [7:0]  opcode,
	input  logic [7:0]  first_operand,
	input  logic [63:0] operand_bits,
	output fields_t     fields
);

	logic [15:0] lo16;
	logic [15:0] hi16;
	logic [31:0] lo32;
	logic [15:0] b16;
	logic [15:0] nib_lo;
	logic [15:0] nib_hi;

	assign lo16   = operand_bits[15:0];
	assign hi16   = operand_bits[31:16];
	assign lo32   = operand_bits[31:0];
	assign b16    = {8'd0, first_operand};
	assign nib_lo = {12'd0, first_operand[3:0]};
	assign nib_hi = {12'd0, first_operand[7:4]};

	always_comb begin
		fields = '0;
		unique case (opcode)
			OP_NOP, OP_RETURN_VOID: begin
				fields = '0;
			end
			OP_MOVE, OP_MOVE_WIDE, OP_MOVE_OBJECT, OP_ARRAY_LENGTH: begin
				fields.reg_a = nib_lo;
				fields.reg_b = nib_hi;
			end
			OP_MOVE_FROM16, OP_MOVE_WIDE_FROM16, OP_MOVE_OBJECT_FROM16: begin
				fields.reg_a = b16;
				fields.reg_b = lo16;
			end
			// pad byte first, then two 16-bit registers
			OP_MOVE_16, OP_MOVE_WIDE_16, OP_MOVE_OBJECT_16: begin
				fields.reg_a = lo16;
				fields.reg_b = hi16;
			end
			OP_CONST_4: begin
				fields.reg_a   = nib_lo;
				fields.literal = {{60{first_operand[7]}}, first_operand[7:4]};
			end
			OP_CONST_16, OP_CONST_WIDE_16: begin
				fields.reg_a   = b16;
				fields.literal = {{48{lo16[15]}}, lo16};
			end
			OP_CONST: begin
				fields.reg_a   = b16;
				fields.literal = {32'd0, lo32};
			end
			OP_CONST_HIGH16: begin
				fields.reg_a   = b16;
				fields.literal = {32'd0, lo16, 16'd0};
			end
			OP_CONST_WIDE_32: begin
				fields.reg_a   = b16;
				fields.literal = {{32{lo32[31]}}, lo32};
			end
			OP_CONST_WIDE: begin
				fields.reg_a   = b16;
				fields.literal = operand_bits;
			end
			OP_CONST_WIDE_HIGH16: begin
				fields.reg_a   = b16;
				fields.literal = {lo16, 48'd0};
			end
			OP_CONST_STRING, OP_CONST_CLASS, OP_CHECK_CAST, OP_NEW_INSTANCE: begin
				fields.reg_a      = b16;
				fields.pool_index = {16'd0, lo16};
			end
			OP_CONST_STRING_JUMBO: begin
				fields.reg_a      = b16;
				fields.pool_index = lo32;
			end
			OP_INSTANCE_OF, OP_NEW_ARRAY: begin
				fields.reg_a      = nib_lo;
				fields.reg_b      = nib_hi;
				fields.pool_index = {16'd0, lo16};
			end
			OP_INVOKE_VIRTUAL_RANGE, OP_INVOKE_SUPER_RANGE, OP_INVOKE_DIRECT_RANGE,
			OP_INVOKE_STATIC_RANGE, OP_INVOKE_IFACE_RANGE: begin
				fields.reg_count  = first_operand;
				fields.pool_index = {16'd0, lo16};
				fields.reg_a      = hi16;
			end
			// single register operand forms
			default: begin
				fields.reg_a = b16;
			end
		endcase
	end

endmodule

/* design/bid_assembler.sv */
// instruction assembler: opcode/operand tracking, skip and drain control, sequence counter
// depends on bid_pkg and bid_fields
module bid_assembler import bid_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] data_byte,
	input  logic       segment_end,
	output logic       res_valid,
	output res_t       res
);

	logic [7:0]           op_q, op_nxt;
	logic [3:0]           pend_q, pend_nxt;
	logic [3:0]           pos_q, pos_nxt;
	logic [2:0]           skip_q, skip_nxt;
	logic                 drain_q, drain_nxt;
	logic [SEQ_WIDTH-1:0] ctr_q, ctr_nxt;
	logic [7:0]           first_q, first_nxt;
	logic [63:0]          bits_q, bits_nxt;
	logic                 clear;
	logic                 use_fields;
	kind_t                kind;
	logic [7:0]           res_op;
	logic [3:0]           size;
	logic [63:0]          ctr_ext;
	fields_t              fields;

	assign size    = op_size(data_byte);
	assign ctr_ext = 64'(ctr_q);

	always_comb begin
		op_nxt     = op_q;
		pend_nxt   = pend_q;
		pos_nxt    = pos_q;
		skip_nxt   = skip_q;
		drain_nxt  = drain_q;
		ctr_nxt    = ctr_q;
		first_nxt  = first_q;
		bits_nxt   = bits_q;
		clear      = 1'b0;
		use_fields = 1'b0;
		res_valid  = 1'b0;
		kind       = KIND_DECODED;
		res_op     = 8'd0;
		if (drain_q) begin
			if (segment_end) begin
				res_valid = 1'b1;
				kind      = KIND_END;
				clear     = 1'b1;
			end
		end else if (skip_q != 3'd0) begin
			skip_nxt = skip_q - 3'd1;
			if (segment_end) begin
				res_valid = 1'b1;
				kind      = KIND_END;
				clear     = 1'b1;
			end
		end else if (pend_q == 4'd0) begin
			if (!is_decoded(data_byte)) begin
				res_valid = 1'b1;
				kind      = KIND_SKIPPED;
				res_op    = data_byte;
				ctr_nxt   = ctr_q + 1'b1;
				skip_nxt  = size[2:0];
				clear     = segment_end;
			end else begin
				op_nxt    = data_byte;
				pend_nxt  = size;
				pos_nxt   = 4'd0;
				first_nxt = 8'd0;
				bits_nxt  = 64'd0;
				if (segment_end) begin
					res_valid = 1'b1;
					kind      = KIND_TRUNC;
					res_op    = data_byte;
					clear     = 1'b1;
				end
			end
		end else begin
			// operand byte: pad/first operand, then little-endian lanes
			if (pos_q == 4'd0) begin
				first_nxt = data_byte;
			end
			for (int i = 0; i < 8; i++) begin
				if (pos_q == 4'(i + 1)) begin
					bits_nxt[8*i +: 8] = data_byte;
				end
			end
			pos_nxt  = pos_q + 4'd1;
			pend_nxt = pend_q - 4'd1;
			res_op   = op_q;
			if (pend_q != 4'd1) begin
				if (segment_end) begin
					res_valid = 1'b1;
					kind      = KIND_TRUNC;
					clear     = 1'b1;
				end
			end else if ((op_q == OP_NOP || op_q == OP_RETURN_VOID) && first_nxt != 8'd0) begin
				res_valid = 1'b1;
				kind      = KIND_BADPAD;
				if (segment_end) begin
					clear = 1'b1;
				end else begin
					drain_nxt = 1'b1;
				end
			end else begin
				res_valid  = 1'b1;
				kind       = KIND_DECODED;
				use_fields = 1'b1;
				ctr_nxt    = ctr_q + 1'b1;
				clear      = segment_end;
			end
		end
	end

	bid_fields u_fields (
		.opcode        (op_q),
		.first_operand (first_nxt),
		.operand_bits  (bits_nxt),
		.fields        (fields)
	);

	always_comb begin
		res                 = '0;
		res.opcode          = res_op;
		res.kind            = kind;
		res.seq_number      = ctr_ext[31:0];
		res.last_of_segment = segment_end;
		if (use_fields) begin
			res.reg_a      = fields.reg_a;
			res.reg_b      = fields.reg_b;
			res.pool_index = fields.pool_index;
			res.reg_count  = fields.reg_count;
			res.literal    = fields.literal;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q    <= 8'd0;
			pend_q  <= 4'd0;
			pos_q   <= 4'd0;
			skip_q  <= 3'd0;
			drain_q <= 1'b0;
			ctr_q   <= SEQ_WIDTH'(1);
		end else if (step) begin
			if (clear) begin
				op_q    <= 8'd0;
				pend_q  <= 4'd0;
				pos_q   <= 4'd0;
				skip_q  <= 3'd0;
				drain_q <= 1'b0;
				ctr_q   <= SEQ_WIDTH'(1);
			end else begin
				op_q    <= op_nxt;
				pend_q  <= pend_nxt;
				pos_q   <= pos_nxt;
				skip_q  <= skip_nxt;
				drain_q <= drain_nxt;
				ctr_q   <= ctr_nxt;
			end
		end
	end

	// operand buffers are cleared whenever an opcode that is decoded is taken
	always_ff @(posedge clk) begin
		if (step) begin
			first_q <= first_nxt;
			bits_q  <= bits_nxt;
		end
	end

	a_modes_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(drain_q && (skip_q != 3'd0)) && !((pend_q != 4'd0) && (drain_q || skip_q != 3'd0)))
		else $error("assembler in more than one mode");

	a_segment_restart: assert property (@(posedge clk) disable iff (!arst_n)
		step && segment_end |=> ctr_q == SEQ_WIDTH'(1) && pend_q == 4'd0 && !drain_q)
		else $error("state not restored after segment end");

	a_end_kinds_last: assert property (@(posedge clk) disable iff (!arst_n)
		step && res_valid && (kind == KIND_END || kind == KIND_TRUNC) |-> segment_end)
		else $error("end or truncation result away from segment end");

	// position may sit one past the last lane once a nine-byte operand is complete
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q == 4'd0 || pos_q <= 4'd8) && pend_q <= 4'd9)
		else $error("operand position out of range");

endmodule

/* design/bytecode_instruction_decoder_core.sv */
// top level of the bytecode instruction decoder: input register, assembler, result register
// depends on bid_pkg and bid_assembler
//
// The decoder takes a bytecode segment one byte per word on the slave stream (s_tlast marks
// the last byte) and reports instructions on the master stream. Opcodes 0x00-0x23 and
// 0x74-0x78 are gathered with their little-endian operands and reported once the last operand
// byte arrives, with register, pool index, count and literal fields filled in. Any other
// opcode is reported as skipped on its opcode byte and its operand bytes are swallowed. A
// nonzero pad after nop or return-void is reported and the rest of the segment is dropped; a
// segment that ends inside an instruction is reported as truncated; a segment that ends while
// bytes are being swallowed gives a segment-end-only word. Sequence numbers restart at 1 in
// each segment. Throughput is one byte per cycle while the master side is not stalled: a byte
// taken into the input register is folded into the assembly state by combinational logic at
// the next edge at which the output register is free, and any result is written to the output
// register at that same edge and held there until accepted. Backpressure on the master side
// stalls the input register only while the output register is still full.
module bytecode_instruction_decoder_core import bid_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// slave stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,   // data_byte
	input  logic                  s_tlast,   // segment_end
	// master stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// opcode[7:0], reg_a[23:8], reg_b[39:24], pool_index[71:40], reg_count[79:72],
	// literal[143:80], seq_number[175:144]
	output logic [TDATA_BITS-1:0] m_tdata,
	output logic [2:0]            m_tuser,   // kind
	output logic                  m_tlast    // last_of_segment
);

	logic       vld_s1;
	logic [7:0] data_s1;
	logic       end_s1;
	logic       out_free;
	logic       step;
	logic       res_valid;
	res_t       res;
	res_t       res_q;
	logic       m_valid_q;

	// output slot is free when empty or being drained this cycle
	assign out_free = !m_valid_q || m_tready;
	assign step     = vld_s1 && out_free;
	assign s_tready = !vld_s1 || out_free;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			data_s1 <= s_tdata;
			end_s1  <= s_tlast;
		end
	end

	bid_assembler u_asm (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.data_byte   (data_s1),
		.segment_end (end_s1),
		.res_valid   (res_valid),
		.res         (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_free) begin
			m_valid_q <= step && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res_valid) begin
			res_q <= res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {res_q.seq_number, res_q.literal, res_q.reg_count, res_q.pool_index,
		res_q.reg_b, res_q.reg_a, res_q.opcode};
	assign m_tuser  = res_q.kind;
	assign m_tlast  = res_q.last_of_segment;

	a_end_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && (res_q.kind == KIND_END || res_q.kind == KIND_TRUNC) |-> res_q.last_of_segment)
		else $error("end or truncation word without last flag");

	a_no_step_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && !m_tready |-> !step)
		else $error("assembler advanced while result register blocked");

	a_end_only_opcode: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && res_q.kind == KIND_END |-> res_q.opcode == 8'd0 && res_q.literal == 64'd0)
		else $error("segment-end word carries payload");

endmodule
